@@ design/pbwm_pkg.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// pbwm_pkg: shared types and constants of the backoff window manager
// Word formats, command codes, the width/limit/m tables and the types
// that travel between the window cells and the top level.
// ----------------------------------------------------------------------------
package pbwm_pkg;

	localparam logic [1:0] FUNC_COLLISION = 2'd0;
	localparam logic [1:0] FUNC_SUCCESS   = 2'd1;
	localparam logic [1:0] FUNC_TIMEOUT   = 2'd2;
	localparam logic [1:0] FUNC_REINIT    = 2'd3;

	localparam logic [7:0] LEVEL_MAX   = 8'd255;
	localparam logic [7:0] WIDE_LEVELS = 8'd4;
	localparam logic [4:0] MK_RESET    = 5'd10;

	typedef struct packed {
		logic [1:0]  func;
		logic [2:0]  prio;
		logic [15:0] random_word;
		logic        reset_widths;
	} in_word_t;

	typedef struct packed {
		logic [6:0] backoff;
		logic [6:0] window_low;
		logic [6:0] window_high;
		logic       mk_violation;
		logic [7:0] collision_level;
	} out_word_t;

	typedef struct packed {
		logic       go;
		logic [6:0] high;
	} chain_t;

	typedef struct packed {
		logic       valid;
		logic [1:0] func;
		logic       reset_widths;
	} cell_cmd_t;

	typedef struct packed {
		logic [6:0] low;
		logic [6:0] high;
		logic [7:0] level;
	} view_t;

	function automatic logic [4:0] width_of(input logic [2:0] lvl);
		logic [4:0] w;
		case (lvl)
			3'd0: w = 5'd1;
			3'd1: w = 5'd3;
			3'd2: w = 5'd6;
			3'd3: w = 5'd10;
			3'd4: w = 5'd16;
			default: w = 5'd16;
		endcase
		return w;
	endfunction

	function automatic logic [6:0] limit_of(input logic [2:0] p);
		logic [6:0] l;
		case (p)
			3'd0: l = 7'd64;
			3'd1: l = 7'd60;
			3'd2: l = 7'd56;
			3'd3: l = 7'd52;
			3'd4: l = 7'd46;
			3'd5: l = 7'd38;
			3'd6: l = 7'd28;
			3'd7: l = 7'd16;
			default: l = 7'd16;
		endcase
		return l;
	endfunction

	function automatic logic [3:0] m_of(input logic [2:0] p);
		logic [3:0] m;
		case (p)
			3'd0: m = 4'd6;
			3'd1: m = 4'd6;
			3'd2: m = 4'd7;
			3'd3: m = 4'd7;
			3'd4: m = 4'd8;
			3'd5: m = 4'd8;
			3'd6: m = 4'd9;
			3'd7: m = 4'd10;
			default: m = 4'd10;
		endcase
		return m;
	endfunction

endpackage
`default_nettype wire

@@ design/priority_backoff_window_manager_unit.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// priority_backoff_window_manager_unit: prioritized contention windows
// Per-priority stacked backoff windows with collision levels, sliding widths,
// backoff draw and (m,k) outcome check, one result word per event word.
// ----------------------------------------------------------------------------
// An event word is held in the pending stage after acceptance and is loaded
// into the output register once the output is free; no new word is taken
// while one is pending. A collision, or a success that narrows the window,
// at priority p re-chains the windows of the lower priorities one cell per
// cycle down the row of window cells; the next word is taken once that wave
// has reached the lowest cell. A reinit walks the whole row the same way,
// and its result word waits for the last cell. A new word is taken while
// the previous result still waits at the output; the one after it stalls
// until that output word is taken.
// ----------------------------------------------------------------------------
module priority_backoff_window_manager_unit #(
	parameter int PRIORITIES  = 8,
	parameter int HISTORY_MAX = 16
) (
	input  wire                   clk,
	input  wire                   arst_n,
	input  wire                   in_valid,
	output logic                  in_stall,
	input  pbwm_pkg::in_word_t    in_word,
	output logic                  out_valid,
	input  wire                   out_stall,
	output pbwm_pkg::out_word_t   out_word,
	input  wire                   cfg_we,
	input  wire [4:0]             cfg_data
);

	localparam int PW = $clog2(PRIORITIES);

	logic                   in_accept;
	logic [2:0]             prio_eff;
	pbwm_pkg::cell_cmd_t    cmd;
	pbwm_pkg::chain_t       top_in;
	pbwm_pkg::chain_t       chain_bus [PRIORITIES];
	pbwm_pkg::view_t        views [PRIORITIES];
	logic [HISTORY_MAX-1:0] hists [PRIORITIES];
	logic                   wave_busy;

	logic [4:0]             mk_window_q;
	logic                   pend_q;
	logic [1:0]             func_s1;
	logic [PW-1:0]          prio_s1;
	logic [15:0]            rnd_s1;
	logic                   out_valid_q;
	pbwm_pkg::out_word_t    out_word_q;
	pbwm_pkg::out_word_t    res;
	logic                   load;
	logic [6:0]             draw_backoff;
	logic                   draw_viol;
	pbwm_pkg::view_t        sel_view;

	assign in_accept = in_valid & ~in_stall;
	assign prio_eff  = (int'(in_word.prio) >= PRIORITIES) ? 3'(PRIORITIES - 1) : in_word.prio;

	assign cmd.valid        = in_accept;
	assign cmd.func         = in_word.func;
	assign cmd.reset_widths = in_word.reset_widths;

	assign top_in.go   = in_accept & (in_word.func == pbwm_pkg::FUNC_REINIT);
	assign top_in.high = 7'd0;

	for (genvar i = 0; i < PRIORITIES; i++) begin : g_cell
		pbwm_cell #(
			.PRIORITIES  (PRIORITIES),
			.HISTORY_MAX (HISTORY_MAX),
			.IDX         (i)
		) u_cell (
			.clk       (clk),
			.arst_n    (arst_n),
			.cmd       (cmd),
			.sel       (prio_eff == 3'(i)),
			.chain_in  ((i == PRIORITIES - 1) ? top_in : chain_bus[(i + 1) % PRIORITIES]),
			.chain_out (chain_bus[i]),
			.view      (views[i]),
			.hist      (hists[i])
		);
	end

	always_comb begin
		wave_busy = 1'b0;
		for (int i = 1; i < PRIORITIES; i++)
			wave_busy = wave_busy | chain_bus[i].go;
	end

	assign in_stall = pend_q | wave_busy;
	assign load     = pend_q & ~(wave_busy & (func_s1 == pbwm_pkg::FUNC_REINIT))
		& (~out_valid_q | ~out_stall);
	assign sel_view = views[prio_s1];

	pbwm_draw #(
		.HISTORY_MAX (HISTORY_MAX)
	) u_draw (
		.low     (sel_view.low),
		.high    (sel_view.high),
		.rnd     (rnd_s1),
		.hist    (hists[prio_s1]),
		.k       (mk_window_q),
		.m       (pbwm_pkg::m_of(3'(prio_s1))),
		.backoff (draw_backoff),
		.viol    (draw_viol)
	);

	always_comb begin
		res.backoff         = (func_s1 == pbwm_pkg::FUNC_COLLISION) ? draw_backoff : 7'd0;
		res.window_low      = sel_view.low;
		res.window_high     = sel_view.high;
		res.mk_violation    = ((func_s1 == pbwm_pkg::FUNC_SUCCESS)
			|| (func_s1 == pbwm_pkg::FUNC_TIMEOUT)) ? draw_viol : 1'b0;
		res.collision_level = sel_view.level;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mk_window_q <= pbwm_pkg::MK_RESET;
			pend_q      <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (cfg_we)
				mk_window_q <= cfg_data;
			if (in_accept)
				pend_q <= 1'b1;
			else if (load)
				pend_q <= 1'b0;
			if (load)
				out_valid_q <= 1'b1;
			else if (!out_stall)
				out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (in_accept) begin
			func_s1 <= in_word.func;
			prio_s1 <= prio_eff[PW-1:0];
			rnd_s1  <= in_word.random_word;
		end
		if (load)
			out_word_q <= res;
	end

	assign out_valid = out_valid_q;
	assign out_word  = out_word_q;

endmodule
`default_nettype wire

@@ design/pbwm_cell.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// pbwm_cell: window cell of one priority
// Holds width, window, collision level, success run and outcome history of
// one priority; takes its window start from the cell above and hands its
// window end to the cell below.
// ----------------------------------------------------------------------------
module pbwm_cell #(
	parameter int PRIORITIES  = 8,
	parameter int HISTORY_MAX = 16,
	parameter int IDX         = 0
) (
	input  wire                       clk,
	input  wire                       arst_n,
	input  pbwm_pkg::cell_cmd_t       cmd,
	input  wire                       sel,
	input  pbwm_pkg::chain_t          chain_in,
	output pbwm_pkg::chain_t          chain_out,
	output pbwm_pkg::view_t           view,
	output logic [HISTORY_MAX-1:0]    hist
);

	localparam logic [6:0] RST_LOW = 7'(1 + 2 * (PRIORITIES - 1 - IDX));
	localparam logic [6:0] LIMIT   = pbwm_pkg::limit_of(3'(IDX));

	logic [4:0]             width_q, width_n;
	logic [6:0]             low_q, low_n;
	logic [6:0]             high_q, high_n;
	logic [7:0]             level_q, level_n;
	logic [1:0]             run_q, run_n;
	logic [HISTORY_MAX-1:0] hist_q, hist_n;
	logic                   go_q;
	logic                   start;
	logic                   recompute;
	logic [7:0]             lvl_inc, lvl_dec, sum_w;

	always_comb begin
		width_n = width_q;
		level_n = level_q;
		run_n   = run_q;
		hist_n  = hist_q;
		start   = 1'b0;
		lvl_inc = (level_q == pbwm_pkg::LEVEL_MAX) ? level_q : level_q + 8'd1;
		lvl_dec = (level_q == 8'd0) ? level_q : level_q - 8'd1;
		if (cmd.valid && cmd.func == pbwm_pkg::FUNC_REINIT) begin
			if (cmd.reset_widths)
				width_n = 5'd1;
			level_n = 8'd0;
			run_n   = 2'd0;
		end else if (cmd.valid && sel) begin
			case (cmd.func)
				pbwm_pkg::FUNC_COLLISION: begin
					run_n   = 2'd0;
					level_n = lvl_inc;
					if (lvl_inc <= pbwm_pkg::WIDE_LEVELS)
						width_n = pbwm_pkg::width_of(lvl_inc[2:0]);
					start = 1'b1;
				end
				pbwm_pkg::FUNC_SUCCESS: begin
					hist_n = {hist_q[HISTORY_MAX-2:0], 1'b1};
					if (run_q >= 2'd2) begin
						run_n   = 2'd1;
						level_n = lvl_dec;
						if (lvl_dec == 8'd0) begin
							width_n = 5'd1;
						end else if (lvl_dec <= pbwm_pkg::WIDE_LEVELS) begin
							width_n = pbwm_pkg::width_of(3'(lvl_dec - 8'd1));
							start   = 1'b1;
						end
					end else begin
						run_n = run_q + 2'd1;
					end
				end
				pbwm_pkg::FUNC_TIMEOUT: begin
					hist_n = {hist_q[HISTORY_MAX-2:0], 1'b0};
				end
				default: begin
					hist_n = hist_q;
				end
			endcase
		end
		low_n     = chain_in.go ? chain_in.high + 7'd1 : low_q;
		recompute = chain_in.go | start;
		sum_w     = {1'b0, low_n} + {3'b000, width_n};
		if (recompute)
			high_n = (sum_w < {1'b0, LIMIT}) ? sum_w[6:0] : LIMIT;
		else
			high_n = high_q;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			width_q <= 5'd1;
			low_q   <= RST_LOW;
			high_q  <= RST_LOW + 7'd1;
			level_q <= 8'd0;
			run_q   <= 2'd0;
			hist_q  <= '1;
			go_q    <= 1'b0;
		end else begin
			width_q <= width_n;
			low_q   <= low_n;
			high_q  <= high_n;
			level_q <= level_n;
			run_q   <= run_n;
			hist_q  <= hist_n;
			go_q    <= recompute;
		end
	end

	assign chain_out.go   = go_q;
	assign chain_out.high = high_q;
	assign view.low       = low_q;
	assign view.high      = high_q;
	assign view.level     = level_q;
	assign hist           = hist_q;

endmodule
`default_nettype wire

@@ design/pbwm_draw.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// pbwm_draw: backoff draw and (m,k) check
// Scales the random word onto the selected window and counts the successes
// among the last k outcomes of the selected history.
// ----------------------------------------------------------------------------
module pbwm_draw #(
	parameter int HISTORY_MAX = 16
) (
	input  wire [6:0]             low,
	input  wire [6:0]             high,
	input  wire [15:0]            rnd,
	input  wire [HISTORY_MAX-1:0] hist,
	input  wire [4:0]             k,
	input  wire [3:0]             m,
	output logic [6:0]            backoff,
	output logic                  viol
);

	localparam int NIB   = (HISTORY_MAX + 3) / 4;
	localparam int PADW  = NIB * 4;
	localparam int CNT_W = $clog2(PADW + 1);

	logic [6:0]             span;
	logic [22:0]            prod;
	logic [7:0]             sum_b;
	logic [5:0]             keff;
	logic [HISTORY_MAX-1:0] masked;
	logic [PADW-1:0]        padded;
	logic [2:0]             nib_cnt [NIB];
	logic [CNT_W-1:0]       cnt;

	always_comb begin
		span    = high - low + 7'd1;
		prod    = 23'(rnd) * 23'(span);
		sum_b   = {1'b0, low} + {1'b0, prod[22:16]};
		backoff = (high >= low) ? sum_b[6:0] : low;
	end

	always_comb begin
		if (k == 5'd0)
			keff = 6'd1;
		else if (int'(k) > HISTORY_MAX)
			keff = 6'(HISTORY_MAX);
		else
			keff = {1'b0, k};
		for (int i = 0; i < HISTORY_MAX; i++)
			masked[i] = hist[i] & (6'(i) < keff);
		padded = '0;
		padded[HISTORY_MAX-1:0] = masked;
		for (int j = 0; j < NIB; j++)
			nib_cnt[j] = 3'(padded[4*j]) + 3'(padded[4*j+1])
				+ 3'(padded[4*j+2]) + 3'(padded[4*j+3]);
		cnt = '0;
		for (int j = 0; j < NIB; j++)
			cnt = cnt + CNT_W'(nib_cnt[j]);
		viol = (8'(cnt) < 8'(m));
	end

endmodule
`default_nettype wire

@@ design/pbwm_checker.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// pbwm_checker: port checks of the backoff window manager
// Watches the ports of the top level and flags words that break the
// handshake or carry inconsistent fields.
// ----------------------------------------------------------------------------
module pbwm_checker (
	input wire                 clk,
	input wire                 arst_n,
	input wire                 in_valid,
	input wire                 in_stall,
	input pbwm_pkg::out_word_t out_word,
	input wire                 out_valid,
	input wire                 out_stall
);

	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid && $stable(out_word))
		else $error("stalled output word changed");

	a_busy_after_accept: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && !in_stall |=> in_stall)
		else $error("input taken again before the result was formed");

	a_backoff_in_window: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_word.backoff != 7'd0 |->
			out_word.backoff >= out_word.window_low && out_word.collision_level != 8'd0)
		else $error("backoff outside its window or without a collision");

	a_one_kind: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> !(out_word.mk_violation && out_word.backoff != 7'd0))
		else $error("backoff and violation in the same word");

endmodule

bind priority_backoff_window_manager_unit pbwm_checker u_pbwm_checker (
	.clk       (clk),
	.arst_n    (arst_n),
	.in_valid  (in_valid),
	.in_stall  (in_stall),
	.out_word  (out_word),
	.out_valid (out_valid),
	.out_stall (out_stall)
);
`default_nettype wire

@@ dv/priority_backoff_window_manager_unit_tb.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// priority_backoff_window_manager_unit_tb: self-checking bench for the window manager
// Sends collision, success, timeout and reinit words under shifting idle and
// stall profiles, predicts every result word from a local copy of the window
// stacks, levels and outcome histories, and compares each field on arrival.
// ----------------------------------------------------------------------------
module priority_backoff_window_manager_unit_tb;

	localparam int PRIORITIES  = 8;
	localparam int HISTORY_MAX = 16;
	localparam int LONG_HOLD   = 150;
	localparam int EXP_DEPTH   = 16;

	localparam logic [4:0][4:0] WIDTH_STEPS = {5'd16, 5'd10, 5'd6, 5'd3, 5'd1};
	localparam logic [7:0][6:0] WINDOW_CAP  = {7'd16, 7'd28, 7'd38, 7'd46,
		7'd52, 7'd56, 7'd60, 7'd64};
	localparam logic [7:0][4:0] MIN_SUCCESS = {5'd10, 5'd9, 5'd8, 5'd8,
		5'd7, 5'd7, 5'd6, 5'd6};

	logic                clk;
	logic                arst_n;
	logic                in_valid;
	logic                in_stall;
	pbwm_pkg::in_word_t  in_word;
	logic                out_valid;
	logic                out_stall;
	pbwm_pkg::out_word_t out_word;
	logic                cfg_we;
	logic [4:0]          cfg_data;

	logic [4:0]  mdl_width [PRIORITIES];
	logic [6:0]  mdl_low   [PRIORITIES];
	logic [6:0]  mdl_high  [PRIORITIES];
	logic [7:0]  mdl_level [PRIORITIES];
	logic [1:0]  mdl_run   [PRIORITIES];
	logic [15:0] mdl_hist  [PRIORITIES];
	logic [4:0]  mdl_k;

	pbwm_pkg::out_word_t exp_fifo [EXP_DEPTH];
	int          exp_wr_idx;
	int          exp_rd_idx;
	int          mismatch_count;
	int          words_sent;
	int          results_checked;
	int          send_idle_pct;
	int          recv_stall_pct;
	logic        long_hold_req;
	logic [2:0]  hot_prio;

	priority_backoff_window_manager_unit #(
		.PRIORITIES  (PRIORITIES),
		.HISTORY_MAX (HISTORY_MAX)
	) dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_stall  (in_stall),
		.in_word   (in_word),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.out_word  (out_word),
		.cfg_we    (cfg_we),
		.cfg_data  (cfg_data)
	);

	initial begin
		clk = 1'b0;
		forever #4 clk = ~clk;
	end

	initial begin
		#2000000;
		$display("%0t: timeout, %0d result words still outstanding", $time,
			exp_wr_idx - exp_rd_idx);
		$display("Mismatches found");
		$finish;
	end

	function automatic void cap_high(input int p);
		int h;
		int lim;
		h = int'(mdl_low[p]) + int'(mdl_width[p]);
		lim = int'(WINDOW_CAP[p]);
		mdl_high[p] = 7'((h < lim) ? h : lim);
	endfunction

	function automatic void restack(input int p);
		int i;
		cap_high(p);
		for (i = p; i > 0; i--) begin
			mdl_low[i - 1] = mdl_high[i] + 7'd1;
			cap_high(i - 1);
		end
	endfunction

	function automatic void reload_windows(input logic clear_widths);
		int i;
		for (i = 0; i < PRIORITIES; i++) begin
			if (clear_widths) begin
				mdl_width[i] = 5'd1;
			end
			mdl_level[i] = '0;
			mdl_run[i] = '0;
		end
		mdl_low[PRIORITIES - 1] = 7'd1;
		restack(PRIORITIES - 1);
	endfunction

	function automatic logic log_outcome(input int p, input logic ok);
		int k;
		int n;
		int i;
		k = int'(mdl_k);
		if (k < 1) begin
			k = 1;
		end
		if (k > HISTORY_MAX) begin
			k = HISTORY_MAX;
		end
		mdl_hist[p] = {mdl_hist[p][HISTORY_MAX-2:0], ok};
		n = 0;
		for (i = 0; i < k; i++) begin
			n += int'(mdl_hist[p][i]);
		end
		return n < int'(MIN_SUCCESS[p]);
	endfunction

	function automatic void reset_windows_model();
		int i;
		mdl_k = pbwm_pkg::MK_RESET;
		for (i = 0; i < PRIORITIES; i++) begin
			mdl_hist[i] = '1;
		end
		reload_windows(1'b1);
	endfunction

	function automatic pbwm_pkg::out_word_t advance_windows(input pbwm_pkg::in_word_t w);
		pbwm_pkg::out_word_t r;
		int p;
		int c;
		int span;
		int rnd;
		r = '0;
		p = int'(w.prio);
		rnd = int'(w.random_word);
		case (w.func)
			pbwm_pkg::FUNC_COLLISION: begin
				c = int'(mdl_level[p]);
				mdl_run[p] = '0;
				if (c < int'(pbwm_pkg::LEVEL_MAX)) begin
					c++;
				end
				mdl_level[p] = 8'(c);
				if (c <= int'(pbwm_pkg::WIDE_LEVELS)) begin
					mdl_width[p] = WIDTH_STEPS[c];
				end
				restack(p);
				if (mdl_high[p] >= mdl_low[p]) begin
					span = int'(mdl_high[p]) - int'(mdl_low[p]) + 1;
					r.backoff = 7'(int'(mdl_low[p]) + ((rnd * span) >> 16));
				end else begin
					r.backoff = mdl_low[p];
				end
			end
			pbwm_pkg::FUNC_SUCCESS: begin
				r.mk_violation = log_outcome(p, 1'b1);
				mdl_run[p] = mdl_run[p] + 2'd1;
				if (mdl_run[p] >= 2'd3) begin
					mdl_run[p] = 2'd1;
					c = int'(mdl_level[p]);
					if (c >= 1) begin
						c--;
					end
					mdl_level[p] = 8'(c);
					if (c == 0) begin
						mdl_width[p] = 5'd1;
					end else if (c <= int'(pbwm_pkg::WIDE_LEVELS)) begin
						mdl_width[p] = WIDTH_STEPS[c - 1];
						restack(p);
					end
				end
			end
			pbwm_pkg::FUNC_TIMEOUT: begin
				r.mk_violation = log_outcome(p, 1'b0);
			end
			pbwm_pkg::FUNC_REINIT: begin
				reload_windows(w.reset_widths);
			end
			default: begin
			end
		endcase
		r.window_low = mdl_low[p];
		r.window_high = mdl_high[p];
		r.collision_level = mdl_level[p];
		return r;
	endfunction

	task automatic report_field(input string name, input int expv, input int actv);
		if (expv != actv) begin
			$display("%0t: %s expected %0d, got %0d", $time, name, expv, actv);
			mismatch_count++;
		end
	endtask

	always @(posedge clk) begin
		pbwm_pkg::out_word_t exp_w;
		if (arst_n && out_valid === 1'b1 && out_stall === 1'b0) begin
			if (exp_wr_idx == exp_rd_idx) begin
				$display("%0t: result word with none expected, got %h", $time, out_word);
				mismatch_count++;
			end else begin
				exp_w = exp_fifo[exp_rd_idx % EXP_DEPTH];
				exp_rd_idx++;
				results_checked++;
				report_field("backoff", exp_w.backoff, out_word.backoff);
				report_field("window_low", exp_w.window_low, out_word.window_low);
				report_field("window_high", exp_w.window_high, out_word.window_high);
				report_field("mk_violation", exp_w.mk_violation, out_word.mk_violation);
				report_field("collision_level", exp_w.collision_level,
					out_word.collision_level);
			end
		end
	end

	initial begin
		int hold_left;
		hold_left = 0;
		out_stall = 1'b0;
		forever begin
			@(posedge clk);
			if (long_hold_req) begin
				hold_left = LONG_HOLD;
				long_hold_req = 1'b0;
			end
			if (hold_left > 0) begin
				hold_left--;
				out_stall <= 1'b1;
			end else begin
				out_stall <= ($urandom_range(99) < recv_stall_pct);
			end
		end
	end

	task automatic send_event(input logic [1:0] f, input logic [2:0] p,
			input logic [15:0] rnd, input logic rw);
		pbwm_pkg::in_word_t w;
		w.func = f;
		w.prio = p;
		w.random_word = rnd;
		w.reset_widths = rw;
		while ($urandom_range(99) < send_idle_pct) begin
			in_valid <= 1'b0;
			@(posedge clk);
		end
		in_valid <= 1'b1;
		in_word <= w;
		@(posedge clk);
		while (in_stall) begin
			@(posedge clk);
		end
		exp_fifo[exp_wr_idx % EXP_DEPTH] = advance_windows(w);
		exp_wr_idx++;
		words_sent++;
	endtask

	task automatic send_random_event();
		int pick;
		logic [1:0] f;
		logic [2:0] p;
		logic [15:0] rnd;
		pick = $urandom_range(99);
		if (pick < 38) begin
			f = pbwm_pkg::FUNC_COLLISION;
		end else if (pick < 72) begin
			f = pbwm_pkg::FUNC_SUCCESS;
		end else if (pick < 95) begin
			f = pbwm_pkg::FUNC_TIMEOUT;
		end else begin
			f = pbwm_pkg::FUNC_REINIT;
		end
		if ($urandom_range(15) == 0) begin
			hot_prio = 3'($urandom_range(7));
		end
		if ($urandom_range(1)) begin
			p = hot_prio;
		end else begin
			p = 3'($urandom_range(7));
		end
		case ($urandom_range(7))
			0: rnd = 16'h0000;
			1: rnd = 16'hFFFF;
			default: rnd = 16'($urandom_range(16'hFFFF));
		endcase
		send_event(f, p, rnd, 1'($urandom_range(1)));
	endtask

	task automatic settle_block();
		in_valid <= 1'b0;
		while (exp_wr_idx != exp_rd_idx) begin
			@(posedge clk);
		end
		repeat (PRIORITIES + 4) @(posedge clk);
	endtask

	task automatic write_k(input logic [4:0] k);
		settle_block();
		cfg_we <= 1'b1;
		cfg_data <= k;
		@(posedge clk);
		cfg_we <= 1'b0;
		mdl_k = k;
	endtask

	task automatic test_directed_commands();
		send_event(pbwm_pkg::FUNC_COLLISION, 3'd7, 16'h0000, 1'b0);
		send_event(pbwm_pkg::FUNC_COLLISION, 3'd7, 16'hFFFF, 1'b1);
		send_event(pbwm_pkg::FUNC_COLLISION, 3'd0, 16'hFFFF, 1'b0);
		send_event(pbwm_pkg::FUNC_COLLISION, 3'd0, 16'h0000, 1'b0);
		repeat (3) send_event(pbwm_pkg::FUNC_SUCCESS, 3'd7, 16'h0000, 1'b0);
		send_event(pbwm_pkg::FUNC_TIMEOUT, 3'd7, 16'hFFFF, 1'b1);
		// level back to zero: width drops, windows stay
		send_event(pbwm_pkg::FUNC_COLLISION, 3'd4, 16'h1234, 1'b0);
		repeat (3) send_event(pbwm_pkg::FUNC_SUCCESS, 3'd4, 16'h0000, 1'b0);
		send_event(pbwm_pkg::FUNC_REINIT, 3'd1, 16'h0000, 1'b0);
		repeat (5) send_event(pbwm_pkg::FUNC_COLLISION, 3'd5, 16'h8000, 1'b0);
		repeat (3) send_event(pbwm_pkg::FUNC_SUCCESS, 3'd5, 16'h0000, 1'b0);
		send_event(pbwm_pkg::FUNC_REINIT, 3'd6, 16'hFFFF, 1'b1);
		write_k(5'd0);
		send_event(pbwm_pkg::FUNC_TIMEOUT, 3'd2, 16'h0000, 1'b0);
		send_event(pbwm_pkg::FUNC_SUCCESS, 3'd2, 16'h0000, 1'b0);
		write_k(5'd31);
		send_event(pbwm_pkg::FUNC_TIMEOUT, 3'd6, 16'h0000, 1'b0);
		send_event(pbwm_pkg::FUNC_SUCCESS, 3'd6, 16'h0000, 1'b0);
		write_k(pbwm_pkg::MK_RESET);
	endtask

	task automatic test_level_saturation();
		int i;
		send_event(pbwm_pkg::FUNC_REINIT, 3'd0, 16'h0000, 1'b1);
		for (i = 0; i < 260; i++) begin
			send_event(pbwm_pkg::FUNC_COLLISION, 3'd2, 16'($urandom_range(16'hFFFF)),
				1'b0);
		end
		repeat (3) send_event(pbwm_pkg::FUNC_SUCCESS, 3'd2, 16'h0000, 1'b0);
		send_event(pbwm_pkg::FUNC_REINIT, 3'd3, 16'h0000, 1'b0);
	endtask

	task automatic test_random_traffic(input int count);
		repeat (count) send_random_event();
	endtask

	task automatic test_output_backpressure(input int count);
		int saved_idle;
		saved_idle = send_idle_pct;
		send_idle_pct = 0;
		long_hold_req = 1'b1;
		repeat (count) send_random_event();
		send_idle_pct = saved_idle;
	endtask

	task automatic test_sender_pause(input int count);
		repeat (count / 2) send_random_event();
		settle_block();
		repeat (count - count / 2) send_random_event();
	endtask

	initial begin
		arst_n = 1'b0;
		in_valid = 1'b0;
		in_word = '0;
		cfg_we = 1'b0;
		cfg_data = '0;
		long_hold_req = 1'b0;
		hot_prio = 3'd0;
		exp_wr_idx = 0;
		exp_rd_idx = 0;
		mismatch_count = 0;
		words_sent = 0;
		results_checked = 0;
		send_idle_pct = 32;
		recv_stall_pct = 65;
		reset_windows_model();
		repeat (4) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_directed_commands();
		test_level_saturation();

		write_k(5'd16);
		test_random_traffic(80);
		test_output_backpressure(40);

		write_k(5'd1);
		send_idle_pct = 65;
		recv_stall_pct = 32;
		test_sender_pause(140);

		write_k(5'($urandom_range(2, 15)));
		send_idle_pct = 0;
		recv_stall_pct = 0;
		test_random_traffic(60);
		write_k(5'd31);
		test_random_traffic(40);

		settle_block();
		$display("Ran %0d event words (all commands, k from 0 to 31, saturated levels)",
			words_sent);
		$display("and checked %0d result words under three idle/stall profiles",
			results_checked);
		if (mismatch_count == 0) begin
			$display("No mismatches found");
		end else begin
			$display("Mismatches found");
		end
		$finish;
	end

endmodule

@@ sim.f @@
design/pbwm_pkg.sv
design/pbwm_cell.sv
design/pbwm_draw.sv
design/priority_backoff_window_manager_unit.sv
design/pbwm_checker.sv
dv/priority_backoff_window_manager_unit_tb.sv
